/* rtl/smct_pkg.sv */
// Shared types, constants and status codes of the sparse-matrix coordinate table.
// No dependencies; every other file takes its names from here.
`timescale 1ns / 1ps
`default_nettype none

package smct_pkg;

    localparam int IDX_FIELD_W   = 10;
    localparam int VAL_FIELD_W   = 32;
    localparam int STATUS_W      = 3;

    localparam int DEF_CAPACITY    = 32;
    localparam int DEF_INDEX_WIDTH = 10;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_DUMP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ENTRY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DUMP     = 3'd5;

    typedef struct packed {
        logic                          kind;
        logic [IDX_FIELD_W-1:0]        row;
        logic [IDX_FIELD_W-1:0]        column;
        logic signed [VAL_FIELD_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]           status;
        logic                          entry_valid;
        logic [IDX_FIELD_W-1:0]        out_row;
        logic [IDX_FIELD_W-1:0]        out_column;
        logic signed [VAL_FIELD_W-1:0] out_value;
        logic                          last;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic exec_set;
        logic dump_first;
        logic dump_next;
    } t_ctrl_cmd;

    typedef struct packed {
        logic kind;
        logic out_last;
    } t_dp_status;

endpackage

`default_nettype wire

/* rtl/smct_in_if.sv */
// Input channel: valid/ready handshake carrying one request beat.
// Depends on smct_pkg for the payload type.
`timescale 1ns / 1ps
`default_nettype none

interface smct_in_if;
    logic                valid;
    logic                ready;
    smct_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/smct_out_if.sv */
// Output channel: valid/ready handshake carrying one result beat.
// Depends on smct_pkg for the payload type.
`timescale 1ns / 1ps
`default_nettype none

interface smct_out_if;
    logic                valid;
    logic                ready;
    smct_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/smct_ctrl.sv */
// Controller FSM of the coordinate table: sequences capture, execute and result beats.
// Depends on smct_pkg for command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module smct_ctrl (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    input  wire smct_pkg::t_dp_status  i_status,
    output smct_pkg::t_ctrl_cmd        o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.kind == smct_pkg::KIND_DUMP) begin
                    o_cmd.dump_first = 1'b1;
                end else begin
                    o_cmd.exec_set = 1'b1;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.out_last) begin
                        // final beat leaves; next request may enter on the same edge
                        o_in_ready = 1'b1;
                        if (i_in_valid) begin
                            o_cmd.capture = 1'b1;
                            n_state       = S_EXEC;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        o_cmd.dump_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/smct_datapath.sv */
// Datapath of the coordinate table: slot registers, parallel match, shift and output beat.
// Depends on smct_pkg; driven by commands from smct_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module smct_datapath #(
    parameter int CAPACITY    = smct_pkg::DEF_CAPACITY,
    parameter int INDEX_WIDTH = smct_pkg::DEF_INDEX_WIDTH,
    parameter int VALUE_WIDTH = smct_pkg::DEF_VALUE_WIDTH
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire smct_pkg::t_in_item    i_in_data,
    input  wire smct_pkg::t_ctrl_cmd   i_cmd,
    output smct_pkg::t_dp_status       o_status,
    output smct_pkg::t_out_item        o_out_data
);

    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FIELD_IW = smct_pkg::IDX_FIELD_W;
    localparam int FIELD_VW = smct_pkg::VAL_FIELD_W;

    logic                   r_kind;
    logic [INDEX_WIDTH-1:0] r_row;
    logic [INDEX_WIDTH-1:0] r_col;
    logic [VALUE_WIDTH-1:0] r_val;

    logic [INDEX_WIDTH-1:0] r_slot_row [CAPACITY];
    logic [INDEX_WIDTH-1:0] r_slot_col [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_slot_val [CAPACITY];

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_idx;
    smct_pkg::t_out_item    r_out;

    logic [CAPACITY-1:0]    hit;
    logic [CAPACITY-1:0]    at_or_after;
    logic                   any_hit;
    logic                   is_full;
    logic                   is_zero;
    logic [IW-1:0]          rd_idx;
    smct_pkg::t_out_item    rd_entry;
    smct_pkg::t_out_item    set_beat;
    logic [CW-1:0]          idx_inc;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            hit[i] = (CW'(i) < r_count) && (r_slot_row[i] == r_row)
                     && (r_slot_col[i] == r_col);
        end
    end

    // entries are unique, so hit is one-hot; bits at and above it mark the gap to close
    assign at_or_after = ~(hit - CAPACITY'(1));
    assign any_hit     = |hit;
    assign is_full     = (r_count == CW'(CAPACITY));
    assign is_zero     = (r_val == '0);
    assign idx_inc     = CW'(r_idx + CW'(1));

    assign rd_idx = i_cmd.dump_first ? '0 : r_idx[IW-1:0];

    always_comb begin
        rd_entry        = '0;
        rd_entry.status = smct_pkg::ST_DUMP;
        if (i_cmd.dump_first && r_count == '0) begin
            // empty table: a single beat with no entry
            rd_entry.last = 1'b1;
        end else begin
            rd_entry.entry_valid = 1'b1;
            rd_entry.out_row     = FIELD_IW'(r_slot_row[rd_idx]);
            rd_entry.out_column  = FIELD_IW'(r_slot_col[rd_idx]);
            rd_entry.out_value   = FIELD_VW'(signed'(r_slot_val[rd_idx]));
            rd_entry.last        = i_cmd.dump_first ? (r_count == CW'(1))
                                                    : (idx_inc == r_count);
        end
    end

    always_comb begin
        set_beat      = '0;
        set_beat.last = 1'b1;
        priority if (is_zero && any_hit) begin
            set_beat.status = smct_pkg::ST_DELETED;
        end else if (is_zero) begin
            set_beat.status = smct_pkg::ST_NO_ENTRY;
        end else if (any_hit) begin
            set_beat.status = smct_pkg::ST_UPDATED;
        end else if (is_full) begin
            set_beat.status = smct_pkg::ST_FULL;
        end else begin
            set_beat.status = smct_pkg::ST_INSERTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec_set) begin
            if (is_zero && any_hit) begin
                r_count <= CW'(r_count - CW'(1));
            end else if (!is_zero && !any_hit && !is_full) begin
                r_count <= CW'(r_count + CW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_in_data.kind;
            r_row  <= INDEX_WIDTH'(i_in_data.row);
            r_col  <= INDEX_WIDTH'(i_in_data.column);
            r_val  <= VALUE_WIDTH'(i_in_data.value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_set) begin
            if (is_zero) begin
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    if (any_hit && at_or_after[i]) begin
                        r_slot_row[i] <= r_slot_row[i+1];
                        r_slot_col[i] <= r_slot_col[i+1];
                        r_slot_val[i] <= r_slot_val[i+1];
                    end
                end
            end else if (any_hit) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (hit[i]) begin
                        r_slot_val[i] <= r_val;
                    end
                end
            end else if (!is_full) begin
                for (int i = 1; i < CAPACITY; i++) begin
                    r_slot_row[i] <= r_slot_row[i-1];
                    r_slot_col[i] <= r_slot_col[i-1];
                    r_slot_val[i] <= r_slot_val[i-1];
                end
                r_slot_row[0] <= r_row;
                r_slot_col[0] <= r_col;
                r_slot_val[0] <= r_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_set) begin
            r_out <= set_beat;
        end else if (i_cmd.dump_first) begin
            r_idx <= CW'(1);
            r_out <= rd_entry;
        end else if (i_cmd.dump_next) begin
            r_idx <= idx_inc;
            r_out <= rd_entry;
        end
    end

    assign o_status.kind     = r_kind;
    assign o_status.out_last = r_out.last;
    assign o_out_data        = r_out;

endmodule

`default_nettype wire

/* rtl/sparse_matrix_coordinate_table.sv */
// Top level of the sparse-matrix coordinate table: controller plus datapath.
// Depends on smct_pkg, smct_in_if, smct_out_if, smct_ctrl and smct_datapath.
//
//  channel  dir  payload                                             beats per request
//  i_in     in   kind, row, column, value                            1
//  o_out    out  status, entry_valid, out_row, out_column,           1 per set,
//                out_value, last                                     1..CAPACITY per dump
//
// A set registers the request, then does the parallel row/column match against all
// slots with the shift or update and registers its result. A dump registers the
// request, then its first beat, then streams one entry a cycle from the slot read mux
// while the output is ready. Requests are held off while a dump streams; a new request
// is taken on the edge that the last result beat leaves. A stalled output holds its beat.
// Reset (synchronous, active low) empties the table at once; slot contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sparse_matrix_coordinate_table #(
    parameter int CAPACITY    = smct_pkg::DEF_CAPACITY,
    parameter int INDEX_WIDTH = smct_pkg::DEF_INDEX_WIDTH,
    parameter int VALUE_WIDTH = smct_pkg::DEF_VALUE_WIDTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    smct_in_if.sink     i_in,
    smct_out_if.source  o_out
);

    smct_pkg::t_ctrl_cmd  cmd;
    smct_pkg::t_dp_status dp_status;

    smct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (dp_status),
        .o_cmd       (cmd)
    );

    smct_datapath #(
        .CAPACITY    (CAPACITY),
        .INDEX_WIDTH (INDEX_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in.data),
        .i_cmd      (cmd),
        .o_status   (dp_status),
        .o_out_data (o_out.data)
    );

endmodule

`default_nettype wire
